FILE: rtl/cdq_pkg.sv
// Package for the circular deque buffer: item structs, command and status codes,
// controller state and the command and status groups between controller and datapath.
// No dependencies.
package cdq_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int VALUE_W       = 32;
    localparam int OCC_W         = 5;

    typedef enum logic [2:0] {
        CMD_RESTART    = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_PUSH_BACK  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4,
        CMD_READ_ALL   = 3'd5
    } cmd_code_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_code_t;

    typedef struct packed {
        logic [2:0]                command;
        logic signed [VALUE_W-1:0] item;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                status;
        logic                      last;
        logic [OCC_W-1:0]          occupancy;
    } out_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    typedef enum logic [2:0] {
        ADDR_ZERO,
        ADDR_HEAD,
        ADDR_BEFORE_HEAD,
        ADDR_TAIL,
        ADDR_LAST,
        ADDR_SCAN
    } addr_sel_t;

    typedef enum logic [1:0] {
        HEAD_HOLD,
        HEAD_ZERO,
        HEAD_DEC,
        HEAD_INC
    } head_op_t;

    typedef enum logic [1:0] {
        COUNT_HOLD,
        COUNT_ONE,
        COUNT_INC,
        COUNT_DEC
    } count_op_t;

    typedef enum logic [1:0] {
        SCAN_HOLD,
        SCAN_LOAD,
        SCAN_INC
    } scan_op_t;

    typedef struct packed {
        logic         ram_we;
        logic         ram_re;
        addr_sel_t    addr_sel;
        head_op_t     head_op;
        count_op_t    count_op;
        scan_op_t     scan_op;
        logic         emit;
        status_code_t emit_status;
        logic         emit_last;
        logic         emit_from_ram;
    } dp_cmd_t;

    typedef struct packed {
        logic is_empty;
        logic is_full;
        logic count_one;
        logic scan_end;
    } dp_status_t;

endpackage

FILE: rtl/circular_deque_buffer_top.sv
// Circular deque buffer top level: controller and datapath. Depends on cdq_pkg,
// cdq_ctrl, cdq_datapath and cdq_ram.
// Every command gives its first result on strobe in the cycle after acceptance.
// Throughput: one command per cycle while busy is low; a read-out of N entries gives one
// result per cycle, with busy high while the rest are read, paced by the single RAM read port.
// Reset: rst_n clears the head index, the count and the controller; entry contents stay
// undefined until written. The receiver cannot stall; results are never held back.
module circular_deque_buffer_top
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  request,
    output logic      strobe,
    output out_item_t result
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (request.command),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd),
        .busy      (busy)
    );

    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (request.item),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .result    (result),
        .strobe    (strobe)
    );

endmodule

FILE: rtl/cdq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/cdq_ctrl.sv
// Controller state machine of the circular deque buffer: decodes commands and sequences
// the read-out. Depends on cdq_pkg.
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] command,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next           = state_reg;
        dp_cmd.ram_we        = 1'b0;
        dp_cmd.ram_re        = 1'b0;
        dp_cmd.addr_sel      = ADDR_HEAD;
        dp_cmd.head_op       = HEAD_HOLD;
        dp_cmd.count_op      = COUNT_HOLD;
        dp_cmd.scan_op       = SCAN_HOLD;
        dp_cmd.emit          = 1'b0;
        dp_cmd.emit_status   = STATUS_OK;
        dp_cmd.emit_last     = 1'b1;
        dp_cmd.emit_from_ram = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    dp_cmd.emit = 1'b1;
                    case (command)
                        CMD_RESTART:
                        begin
                            dp_cmd.ram_we   = 1'b1;
                            dp_cmd.addr_sel = ADDR_ZERO;
                            dp_cmd.head_op  = HEAD_ZERO;
                            dp_cmd.count_op = COUNT_ONE;
                        end
                        CMD_PUSH_FRONT:
                        begin
                            if (dp_status.is_full)
                            begin
                                dp_cmd.emit_status = STATUS_FULL;
                            end
                            else
                            begin
                                dp_cmd.ram_we   = 1'b1;
                                dp_cmd.addr_sel = ADDR_BEFORE_HEAD;
                                dp_cmd.head_op  = HEAD_DEC;
                                dp_cmd.count_op = COUNT_INC;
                            end
                        end
                        CMD_PUSH_BACK:
                        begin
                            if (dp_status.is_full)
                            begin
                                dp_cmd.emit_status = STATUS_FULL;
                            end
                            else
                            begin
                                dp_cmd.ram_we   = 1'b1;
                                dp_cmd.addr_sel = ADDR_TAIL;
                                dp_cmd.count_op = COUNT_INC;
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (dp_status.is_empty)
                            begin
                                dp_cmd.emit_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                dp_cmd.ram_re        = 1'b1;
                                dp_cmd.addr_sel      = ADDR_HEAD;
                                dp_cmd.head_op       = HEAD_INC;
                                dp_cmd.count_op      = COUNT_DEC;
                                dp_cmd.emit_from_ram = 1'b1;
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (dp_status.is_empty)
                            begin
                                dp_cmd.emit_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                dp_cmd.ram_re        = 1'b1;
                                dp_cmd.addr_sel      = ADDR_LAST;
                                dp_cmd.count_op      = COUNT_DEC;
                                dp_cmd.emit_from_ram = 1'b1;
                            end
                        end
                        CMD_READ_ALL:
                        begin
                            if (dp_status.is_empty)
                            begin
                                dp_cmd.emit_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                dp_cmd.ram_re        = 1'b1;
                                dp_cmd.addr_sel      = ADDR_HEAD;
                                dp_cmd.scan_op       = SCAN_LOAD;
                                dp_cmd.emit_from_ram = 1'b1;
                                dp_cmd.emit_last     = dp_status.count_one;
                                if (!dp_status.count_one)
                                begin
                                    state_next = ST_DUMP;
                                end
                            end
                        end
                        default:
                        begin
                            dp_cmd.emit_status = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                dp_cmd.emit          = 1'b1;
                dp_cmd.ram_re        = 1'b1;
                dp_cmd.addr_sel      = ADDR_SCAN;
                dp_cmd.scan_op       = SCAN_INC;
                dp_cmd.emit_from_ram = 1'b1;
                dp_cmd.emit_last     = dp_status.scan_end;
                if (dp_status.scan_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == ST_DUMP);

endmodule

FILE: rtl/cdq_datapath.sv
// Datapath of the circular deque buffer: head and count registers, ring address
// arithmetic, entry RAM and the result register. Depends on cdq_pkg and cdq_ram.
module cdq_datapath
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [VALUE_W-1:0] item,
    input  dp_cmd_t                   dp_cmd,
    output dp_status_t                dp_status,
    output out_item_t                 result,
    output logic                      strobe
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0]      head_reg;
    logic [AW-1:0]      head_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [AW-1:0]      scan_reg;
    logic [AW-1:0]      scan_next;
    logic               strobe_reg;
    logic [1:0]         status_reg;
    logic               last_reg;
    logic [CW-1:0]      occ_reg;
    logic               from_ram_reg;
    logic [AW-1:0]      head_before;
    logic [AW-1:0]      head_after;
    logic [AW-1:0]      addr;
    logic [VALUE_W-1:0] rd_data;
    logic [CW+OCC_W-1:0] occ_wide;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] offset);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign head_before = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign head_after  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_comb
    begin
        case (dp_cmd.addr_sel)
            ADDR_ZERO:        addr = '0;
            ADDR_HEAD:        addr = head_reg;
            ADDR_BEFORE_HEAD: addr = head_before;
            ADDR_TAIL:        addr = ring_add(head_reg, count_reg[AW-1:0]);
            ADDR_LAST:        addr = ring_add(head_reg, AW'(count_reg - 1'b1));
            ADDR_SCAN:        addr = ring_add(head_reg, scan_reg);
            default:          addr = head_reg;
        endcase
    end

    always_comb
    begin
        case (dp_cmd.head_op)
            HEAD_ZERO: head_next = '0;
            HEAD_DEC:  head_next = head_before;
            HEAD_INC:  head_next = head_after;
            default:   head_next = head_reg;
        endcase
        case (dp_cmd.count_op)
            COUNT_ONE: count_next = CW'(1);
            COUNT_INC: count_next = count_reg + 1'b1;
            COUNT_DEC: count_next = count_reg - 1'b1;
            default:   count_next = count_reg;
        endcase
        case (dp_cmd.scan_op)
            SCAN_LOAD: scan_next = AW'(1);
            SCAN_INC:  scan_next = scan_reg + 1'b1;
            default:   scan_next = scan_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            scan_reg     <= '0;
            strobe_reg   <= 1'b0;
            from_ram_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            strobe_reg   <= dp_cmd.emit;
            from_ram_reg <= dp_cmd.emit_from_ram;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.emit)
        begin
            status_reg <= dp_cmd.emit_status;
            last_reg   <= dp_cmd.emit_last;
            occ_reg    <= count_next;
        end
    end

    cdq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (dp_cmd.ram_we),
        .waddr (addr),
        .wdata (item),
        .re    (dp_cmd.ram_re),
        .raddr (addr),
        .rdata (rd_data)
    );

    assign dp_status.is_empty  = (count_reg == '0);
    assign dp_status.is_full   = (count_reg == CW'(DEPTH));
    assign dp_status.count_one = (count_reg == CW'(1));
    assign dp_status.scan_end  = ((CW'(scan_reg) + 1'b1) == count_reg);

    assign occ_wide         = {{OCC_W{1'b0}}, occ_reg};
    assign result.value     = from_ram_reg ? $signed(rd_data) : '0;
    assign result.status    = status_reg;
    assign result.last      = last_reg;
    assign result.occupancy = occ_wide[OCC_W-1:0];
    assign strobe           = strobe_reg;

endmodule

FILE: rtl/cdq_checker.sv
// Port-level assertions for the circular deque buffer and the bind that attaches them
// to the top level. Depends on cdq_pkg.
module cdq_checker
    import cdq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      strobe,
    input out_item_t result
);

    // Every accepted command produces its first result in the next cycle.
    a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> strobe)
        else $error("accepted command gave no result in the next cycle");

    a_busy_emits: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> strobe)
        else $error("read-out stalled while busy");

    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last) |-> busy)
        else $error("non-final result while not busy");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (result.status != STATUS_OK)) |-> result.last)
        else $error("error status on a non-final result");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (result.status == STATUS_EMPTY)) |-> (result.occupancy == '0))
        else $error("empty status with nonzero occupancy");

endmodule

bind circular_deque_buffer_top cdq_checker u_cdq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);

FILE: verif/circular_deque_buffer_top_tb.sv
// Self-checking testbench for circular_deque_buffer_top: a table of directed commands, then
// random commands with random start gaps, checked against the table or a deque predictor.
// Depends on cdq_pkg and the circular deque buffer RTL.
module circular_deque_buffer_top_tb
    import cdq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEFAULT_DEPTH;
    localparam int RANDOM_ITEMS = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] item;
        logic [4:0]  repeats;
        bit          typed;
        out_item_t   expected;
    } directed_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    in_item_t  request = '0;
    logic      strobe;
    out_item_t result;

    logic signed [31:0] model_ring [DEPTH];
    int unsigned        model_head;
    int unsigned        model_count;
    out_item_t          step_results[$];
    out_item_t          pending_results[$];
    directed_row_t      directed_rows[$];
    int                 error_count = 0;
    int                 no_idle_left = 0;

    circular_deque_buffer_top #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .strobe(strobe),
        .result(result)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic out_item_t make_result(input logic [31:0] value,
                                              input logic [1:0] status,
                                              input logic last);
        out_item_t r;
        r.value = value;
        r.status = status;
        r.last = last;
        r.occupancy = model_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic run_deque_command(input in_item_t cmd_item);
        logic [31:0] popped;
        logic [1:0]  status;
        int unsigned i;
        popped = '0;
        status = STATUS_OK;
        step_results.delete();
        case (cmd_item.command)
            CMD_RESTART:
            begin
                model_head = 0;
                model_ring[0] = cmd_item.item;
                model_count = 1;
            end
            CMD_PUSH_FRONT:
            begin
                if (model_count >= DEPTH)
                begin
                    status = STATUS_FULL;
                end
                else
                begin
                    model_head = (model_head + DEPTH - 1) % DEPTH;
                    model_ring[model_head] = cmd_item.item;
                    model_count++;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (model_count >= DEPTH)
                begin
                    status = STATUS_FULL;
                end
                else
                begin
                    model_ring[(model_head + model_count) % DEPTH] = cmd_item.item;
                    model_count++;
                end
            end
            CMD_POP_FRONT:
            begin
                if (model_count == 0)
                begin
                    status = STATUS_EMPTY;
                end
                else
                begin
                    popped = model_ring[model_head];
                    model_head = (model_head + 1) % DEPTH;
                    model_count--;
                end
            end
            CMD_POP_BACK:
            begin
                if (model_count == 0)
                begin
                    status = STATUS_EMPTY;
                end
                else
                begin
                    popped = model_ring[(model_head + model_count - 1) % DEPTH];
                    model_count--;
                end
            end
            CMD_READ_ALL:
            begin
                if (model_count == 0)
                begin
                    status = STATUS_EMPTY;
                end
                else
                begin
                    for (i = 0; i < model_count; i++)
                    begin
                        step_results.push_back(make_result(
                            model_ring[(model_head + i) % DEPTH], STATUS_OK,
                            i + 1 == model_count));
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (step_results.size() == 0)
        begin
            step_results.push_back(make_result(popped, status, 1'b1));
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle_left > 0)
        begin
            no_idle_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            no_idle_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_command(input in_item_t cmd_item, input bit typed,
                                input out_item_t typed_result);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= cmd_item;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        run_deque_command(cmd_item);
        if (typed)
        begin
            pending_results.push_back(typed_result);
        end
        else
        begin
            foreach (step_results[k])
            begin
                pending_results.push_back(step_results[k]);
            end
        end
    endtask

    task automatic add_row(input logic [2:0] command, input logic [31:0] item,
                           input int repeats, input bit typed, input logic [31:0] value,
                           input logic [1:0] status, input int occupancy);
        directed_row_t row;
        row.command = command;
        row.item = item;
        row.repeats = repeats[4:0];
        row.typed = typed;
        row.expected.value = value;
        row.expected.status = status;
        row.expected.last = 1'b1;
        row.expected.occupancy = occupancy[OCC_W-1:0];
        directed_rows.push_back(row);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 31))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_command(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            return CMD_RESTART;
        end
        if (r >= 98)
        begin
            return (r == 98) ? CMD_SPARE_6 : CMD_SPARE_7;
        end
        if (filling)
        begin
            if (r < 37) return CMD_PUSH_FRONT;
            if (r < 72) return CMD_PUSH_BACK;
            if (r < 80) return CMD_POP_FRONT;
            if (r < 88) return CMD_POP_BACK;
            return CMD_READ_ALL;
        end
        if (r < 12) return CMD_PUSH_FRONT;
        if (r < 22) return CMD_PUSH_BACK;
        if (r < 52) return CMD_POP_FRONT;
        if (r < 82) return CMD_POP_BACK;
        return CMD_READ_ALL;
    endfunction

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n === 1'b1 && strobe !== 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", result));
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.value !== want.value)
                    report_mismatch($sformatf("value got %h exp %h", result.value,
                                              want.value));
                if (result.status !== want.status)
                    report_mismatch($sformatf("status got %0d exp %0d", result.status,
                                              want.status));
                if (result.last !== want.last)
                    report_mismatch($sformatf("last got %b exp %b", result.last, want.last));
                if (result.occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy got %0d exp %0d",
                                              result.occupancy, want.occupancy));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        in_item_t cmd_item;
        out_item_t typed_result;
        bit filling;
        int phase_left;
        int n;
        model_head = 0;
        model_count = 0;
        foreach (model_ring[k])
        begin
            model_ring[k] = '0;
        end

        add_row(CMD_POP_FRONT, 32'h1234_5678, 1, 1, 32'h0, STATUS_EMPTY, 0);
        add_row(CMD_POP_BACK, 32'hFFFF_FFFF, 1, 1, 32'h0, STATUS_EMPTY, 0);
        add_row(CMD_READ_ALL, 32'h0, 1, 1, 32'h0, STATUS_EMPTY, 0);
        add_row(CMD_SPARE_6, 32'hDEAD_BEEF, 1, 1, 32'h0, STATUS_OK, 0);
        add_row(CMD_RESTART, 32'h8000_0000, 1, 1, 32'h0, STATUS_OK, 1);
        add_row(CMD_PUSH_FRONT, 32'h7FFF_FFFF, DEPTH - 1, 0, 32'h0, STATUS_OK, 0);
        add_row(CMD_PUSH_BACK, 32'h0, 1, 1, 32'h0, STATUS_FULL, DEPTH);
        add_row(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1, 32'h0, STATUS_FULL, DEPTH);
        add_row(CMD_READ_ALL, 32'h0, 1, 0, 32'h0, STATUS_OK, 0);
        add_row(CMD_POP_BACK, 32'h0, 1, 1, 32'h8000_0000, STATUS_OK, DEPTH - 1);
        add_row(CMD_POP_FRONT, 32'h0, 1, 1, 32'h7FFF_FFFF, STATUS_OK, DEPTH - 2);
        add_row(CMD_SPARE_7, 32'hFFFF_FFFF, 1, 1, 32'h0, STATUS_OK, DEPTH - 2);
        add_row(CMD_RESTART, 32'h0000_0001, 1, 1, 32'h0, STATUS_OK, 1);
        add_row(CMD_PUSH_BACK, 32'hFFFF_FFFF, 1, 1, 32'h0, STATUS_OK, 2);
        add_row(CMD_POP_FRONT, 32'h0, 1, 1, 32'h0000_0001, STATUS_OK, 1);
        add_row(CMD_READ_ALL, 32'h0, 1, 0, 32'h0, STATUS_OK, 0);
        add_row(CMD_POP_BACK, 32'h0, 1, 1, 32'hFFFF_FFFF, STATUS_OK, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            cmd_item.command = directed_rows[r].command;
            cmd_item.item = directed_rows[r].item;
            typed_result = directed_rows[r].expected;
            for (n = 0; n < directed_rows[r].repeats; n++)
            begin
                send_command(cmd_item, directed_rows[r].typed, typed_result);
            end
        end

        filling = 1'b1;
        phase_left = $urandom_range(20, 60);
        typed_result = '0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                filling = !filling;
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            cmd_item.command = pick_command(filling);
            cmd_item.item = pick_value();
            send_command(cmd_item, 1'b0, typed_result);
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
